/* src/vrd_pkg.sv */
// vrd_pkg: shared types and constants of the voxel ray caster
// no dependencies; used by every module of the block
package vrd_pkg;

  localparam int DELTA_W = 31;   // floor(2^30 / |dir|)
  localparam int FRAC_W  = 17;   // distance to the next boundary, up to 65536
  localparam int SIDE_W  = 57;   // side distance in Q.32, grows over the walk
  localparam int PROD_W  = 48;
  localparam int STEP_W  = 10;
  localparam int QDEPTH  = 4;
  localparam int QAW     = 2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_LEFT  = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  localparam logic [23:0] COLOUR_X = 24'h0000FF;
  localparam logic [23:0] COLOUR_Y = 24'h00FF00;
  localparam logic [23:0] COLOUR_Z = 24'hFF0000;

  typedef enum logic [1:0] {FR_IDLE, FR_DIV, FR_PUSH} vrd_front_e;

  typedef enum logic [2:0] {
    BK_CLEAR, BK_IDLE, BK_MUL, BK_READ, BK_CHECK, BK_DONE
  } vrd_back_e;

  typedef struct packed {
    logic                          is_cast;
    logic [2:0][4:0]               org_cell;
    logic [2:0][FRAC_W-1:0]        fnext;
    logic [2:0]                    neg;
    logic [2:0]                    inf;
    logic [2:0][DELTA_W-1:0]       delta;
    logic [2:0][4:0]               wcell;
    logic                          fill;
  } vrd_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        axis;
    logic [2:0][4:0]   hit;
    logic [23:0]       colour;
    logic [STEP_W-1:0] steps;
  } vrd_result_t;

endpackage

/* src/vrd_recip.sv */
// vrd_recip: restoring divider giving floor(2^30 / divisor), one bit a cycle
// depends on vrd_pkg
module vrd_recip
  import vrd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        divisor_i,
  output logic               busy_o,
  output logic [DELTA_W-1:0] quot_o
);

  logic               busy_q;
  logic [4:0]         cnt_q;
  logic [15:0]        rem_q, div_q;
  logic [DELTA_W-1:0] quot_q;
  logic [16:0]        trial;
  logic               qbit;

  // dividend is a single one at the top bit
  assign trial = {rem_q, (cnt_q == 5'(DELTA_W - 1))};
  assign qbit  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && cnt_q == 5'd0) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q  <= 5'(DELTA_W - 1);
      rem_q  <= '0;
      quot_q <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= qbit ? 16'(trial - {1'b0, div_q}) : trial[15:0];
      quot_q <= {quot_q[DELTA_W-2:0], qbit};
      cnt_q  <= cnt_q - 5'd1;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

/* src/vrd_front.sv */
// vrd_front: accepts items, classifies write or cast and sets up each axis
// depends on vrd_pkg and vrd_recip
module vrd_front
  import vrd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         cmd_i,
  input  logic [127:0] data_i,
  output logic         push_o,
  output vrd_item_t    push_item_o,
  input  logic         full_i
);

  vrd_front_e state_q, state_d;
  vrd_item_t  hold_q;
  logic       accept, start;
  logic [2:0] busy;
  logic [2:0][15:0]        mag;
  logic [2:0][DELTA_W-1:0] quot;
  logic [2:0][20:0]        org;
  logic [2:0][15:0]        dir;

  assign org[0] = data_i[20:0];
  assign org[1] = data_i[41:21];
  assign org[2] = data_i[62:42];
  assign dir[0] = data_i[78:63];
  assign dir[1] = data_i[94:79];
  assign dir[2] = data_i[110:95];

  assign accept = in_valid_i && in_ready_o;
  assign start  = accept && cmd_i;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    assign mag[k] = dir[k][15] ? 16'(-dir[k]) : dir[k];
    vrd_recip u_recip (
      .clk_i, .rst_ni,
      .start_i(start), .divisor_i(mag[k]),
      .busy_o(busy[k]), .quot_o(quot[k])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_IDLE: if (accept) state_d = cmd_i ? FR_DIV : FR_PUSH;
      FR_DIV:  if (busy == 3'b000) state_d = FR_PUSH;
      FR_PUSH: if (!full_i) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == FR_IDLE);
    push_o      = (state_q == FR_PUSH) && !full_i;
    push_item_o = hold_q;
    push_item_o.delta = quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= FR_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q.is_cast <= cmd_i;
      for (int k = 0; k < 3; k++) begin
        hold_q.org_cell[k] <= org[k][20:16];
        hold_q.neg[k]      <= dir[k][15];
        hold_q.inf[k]      <= (mag[k] == 16'd0);
        hold_q.fnext[k]    <= dir[k][15] ? {1'b0, org[k][15:0]}
                                         : 17'h10000 - {1'b0, org[k][15:0]};
        hold_q.delta[k]    <= '0;
      end
      hold_q.wcell[0] <= data_i[115:111];
      hold_q.wcell[1] <= data_i[120:116];
      hold_q.wcell[2] <= data_i[125:121];
      hold_q.fill     <= data_i[126];
    end
  end

endmodule

/* src/vrd_queue.sv */
// vrd_queue: short fifo of set-up items between front and back
// depends on vrd_pkg
module vrd_queue
  import vrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  vrd_item_t push_item_i,
  output logic      full_o,
  input  logic      pop_i,
  output vrd_item_t head_o,
  output logic      empty_o
);

  vrd_item_t        buf_q [QDEPTH];
  logic [QAW-1:0]   wptr_q, rptr_q;
  logic [QAW:0]     cnt_q;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = buf_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (QAW+1)'(push_i) - (QAW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wptr_q] <= push_item_i;
  end

endmodule

/* src/vrd_back.sv */
// vrd_back: occupancy map and the cell walk, plus the result register
// depends on vrd_pkg
module vrd_back
  import vrd_pkg::*;
#(
  parameter int MAP_DIM = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  vrd_item_t         head_i,
  output logic              pop_o,
  input  logic [STEP_W-1:0] max_steps_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vrd_result_t       out_o
);

  localparam int CW  = $clog2(MAP_DIM);
  localparam int RAW = $clog2(MAP_DIM * MAP_DIM);
  localparam logic [SIDE_W:0] KEY_INF = '1;

  vrd_back_e state_q, state_d;
  logic [RAW-1:0]     clr_q;
  vrd_item_t          cur_q;
  logic [2:0][CW-1:0] cell_q;
  logic [2:0][SIDE_W-1:0] side_q;
  logic [1:0]         axis_q, sel_q;
  logic [STEP_W-1:0]  steps_q;
  vrd_result_t        res_q, out_q;
  logic               out_valid_q;
  logic [MAP_DIM-1:0] mem [MAP_DIM*MAP_DIM];
  logic [MAP_DIM-1:0] rd_q;

  logic               out_free, load_out, clr_last;
  logic               org_out, wr_in, occ, lim, leaving;
  logic [2:0][SIDE_W:0]   key;
  logic [2:0][PROD_W-1:0] prod;
  logic [1:0]         sel;
  logic [RAW-1:0]     wrow, rrow;

  assign out_free = !out_valid_q || out_ready_i;
  assign clr_last = (clr_q == RAW'(MAP_DIM * MAP_DIM - 1));
  assign org_out  = (32'(cur_q.org_cell[0]) >= MAP_DIM) ||
                    (32'(cur_q.org_cell[1]) >= MAP_DIM) ||
                    (32'(cur_q.org_cell[2]) >= MAP_DIM);
  assign wr_in    = (32'(head_i.wcell[0]) < MAP_DIM) &&
                    (32'(head_i.wcell[1]) < MAP_DIM) &&
                    (32'(head_i.wcell[2]) < MAP_DIM);
  assign wrow = RAW'(head_i.wcell[0]) * RAW'(MAP_DIM) + RAW'(head_i.wcell[1]);
  assign rrow = RAW'(cell_q[0]) * RAW'(MAP_DIM) + RAW'(cell_q[1]);
  assign occ  = rd_q[cell_q[2]];
  assign lim  = (steps_q >= max_steps_i);
  assign leaving = cur_q.neg[sel_q] ? (cell_q[sel_q] == '0)
                                    : (cell_q[sel_q] == CW'(MAP_DIM - 1));

  // infinite distance sorts above every finite one, and ties with itself
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      key[k]  = cur_q.inf[k] ? KEY_INF : {1'b0, side_q[k]};
      prod[k] = PROD_W'(cur_q.fnext[k]) * PROD_W'(cur_q.delta[k]);
    end
    if (key[1] < key[0]) sel = (key[1] < key[2]) ? AXIS_Y : AXIS_Z;
    else                 sel = (key[0] < key[2]) ? AXIS_X : AXIS_Z;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: if (clr_last) state_d = BK_IDLE;
      BK_IDLE:  if (!empty_i && head_i.is_cast) state_d = BK_MUL;
      BK_MUL:   state_d = org_out ? BK_DONE : BK_READ;
      BK_READ:  state_d = BK_CHECK;
      BK_CHECK: if (occ || lim || leaving) state_d = BK_DONE;
                else                       state_d = BK_READ;
      BK_DONE:  if (out_free) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == BK_IDLE) && !empty_i;
    load_out = (state_q == BK_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
    if (load_out) out_q <= res_q;
    unique case (state_q)
      BK_MUL: begin
        for (int k = 0; k < 3; k++) begin
          side_q[k] <= SIDE_W'(prod[k]);
          cell_q[k] <= CW'(cur_q.org_cell[k]);
        end
        axis_q  <= AXIS_X;
        steps_q <= '0;
        res_q.status <= ST_LEFT;
        res_q.axis   <= AXIS_X;
        res_q.hit    <= cur_q.org_cell;
        res_q.colour <= '0;
        res_q.steps  <= '0;
      end
      BK_READ: sel_q <= sel;
      BK_CHECK: begin
        res_q.colour <= '0;
        for (int k = 0; k < 3; k++) res_q.hit[k] <= 5'(cell_q[k]);
        if (occ) begin
          res_q.status <= ST_HIT;
          res_q.axis   <= axis_q;
          res_q.steps  <= steps_q;
          case (axis_q)
            AXIS_X:  res_q.colour <= COLOUR_X;
            AXIS_Y:  res_q.colour <= COLOUR_Y;
            default: res_q.colour <= COLOUR_Z;
          endcase
        end else if (lim) begin
          res_q.status <= ST_LIMIT;
          res_q.axis   <= axis_q;
          res_q.steps  <= steps_q;
        end else begin
          if (!cur_q.inf[sel_q])
            side_q[sel_q] <= side_q[sel_q] + SIDE_W'({cur_q.delta[sel_q], 16'b0});
          axis_q       <= sel_q;
          steps_q      <= steps_q + 1'b1;
          res_q.status <= ST_LEFT;
          res_q.axis   <= sel_q;
          res_q.steps  <= steps_q + 1'b1;
          if (!leaving)
            cell_q[sel_q] <= cur_q.neg[sel_q] ? cell_q[sel_q] - 1'b1
                                              : cell_q[sel_q] + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // map storage: one row of z cells per (x, y)
  always_ff @(posedge clk_i) begin
    if (state_q == BK_CLEAR)
      mem[clr_q] <= '0;
    else if (pop_o && !head_i.is_cast && wr_in)
      mem[wrow][CW'(head_i.wcell[2])] <= head_i.fill;
    if (state_q == BK_READ) rd_q <= mem[rrow];
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* src/voxel_ray_dda_traversal.sv */
// voxel ray caster: write items update the map, cast items walk it cell by cell
// a cast runs through the reciprocals, the queue hop and the map set-up, then each cell step
// takes a map read and a check; a write reaches the map when the back pops it from the queue
// throughput: reciprocals of the next cast overlap the walk of the current one
// reset: map cleared by a pass over all MAP_DIM*MAP_DIM rows (1024 by default), items queue
// up meanwhile and wait for the pass to end; max_steps resets to 96
module voxel_ray_dda_traversal
  import vrd_pkg::*;
#(
  parameter int MAP_DIM = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, cell_wx, cell_wy, cell_wz, fill
  input  logic [127:0] s_axis_tdata,
  // cmd
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // face_axis, hit_x, hit_y, hit_z, colour, step_count
  output logic [55:0]  m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [9:0]   cfg_data_i
);

  logic [STEP_W-1:0] max_steps_q;
  logic        push, full, pop, empty;
  vrd_item_t   push_item, head;
  vrd_result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                         max_steps_q <= 10'd96;
    else if (cfg_valid_i && cfg_ready_o) max_steps_q <= cfg_data_i;
  end

  vrd_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser), .data_i(s_axis_tdata),
    .push_o(push), .push_item_o(push_item), .full_i(full)
  );

  vrd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_item_i(push_item), .full_o(full),
    .pop_i(pop), .head_o(head), .empty_o(empty)
  );

  vrd_back #(.MAP_DIM(MAP_DIM)) u_back (
    .clk_i, .rst_ni,
    .empty_i(empty), .head_i(head), .pop_o(pop),
    .max_steps_i(max_steps_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_o(res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {5'b0, res.steps, res.colour, res.hit[2], res.hit[1],
                         res.hit[0], res.axis};

endmodule
